>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSORT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`define MSORT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");
`else
`define MSORT_ASSERT_NEVER(label, clk, rst_n, cond)
`define MSORT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/msort_pkg.sv
// types shared by the sort engine: payload structs, cell slot, fsm states
// no dependencies
`default_nettype none
package msort_pkg;

  typedef logic signed [31:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  last_item;
  } in_item_t;

  typedef struct packed {
    elem_t sorted_value;
    logic  end_of_run;
  } out_item_t;

  // one element moving between cells, or held in a cell
  typedef struct packed {
    logic  valid;
    elem_t data;
  } slot_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/msort_cell.sv
// one cell of the systolic sorting chain: keeps the smaller element, passes the larger
// depends on msort_pkg
`default_nettype none
module msort_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire msort_pkg::slot_t pass_in,
  input  wire msort_pkg::slot_t right_hold,
  output msort_pkg::slot_t      hold,
  output msort_pkg::slot_t      pass_out
);

  logic            hold_v_r, hold_v_nxt;
  msort_pkg::elem_t hold_d_r, hold_d_nxt;
  logic            pass_v_r, pass_v_nxt;
  msort_pkg::elem_t pass_d_r, pass_d_nxt;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_d_nxt = hold_d_r;
    pass_v_nxt = 1'b0;
    pass_d_nxt = pass_in.data;
    if (shift_en) begin
      // emit: the chain moves one place toward the head
      hold_v_nxt = right_hold.valid;
      hold_d_nxt = right_hold.data;
    end else if (pass_in.valid) begin
      if (!hold_v_r) begin
        hold_v_nxt = 1'b1;
        hold_d_nxt = pass_in.data;
      end else if (pass_in.data < hold_d_r) begin
        hold_d_nxt = pass_in.data;
        pass_v_nxt = 1'b1;
        pass_d_nxt = hold_d_r;
      end else begin
        pass_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      pass_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      pass_v_r <= pass_v_nxt;
    end
    hold_d_r <= hold_d_nxt;
    pass_d_r <= pass_d_nxt;
  end

  assign hold     = '{valid: hold_v_r, data: hold_d_r};
  assign pass_out = '{valid: pass_v_r, data: pass_d_r};

endmodule
`default_nettype wire

>>> rtl/core/merge_sort_engine.sv
// top level of the sort engine: cell chain plus load / drain / emit sequencer
// depends on msort_pkg, msort_cell and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// Sort engine for sets of up to MAX_ITEMS signed 32-bit values. A transfer is
// taken on a clock edge with start high and busy low; one value per transfer,
// and last_item (or the transfer that fills the store) closes the set. Loading
// runs at one value per cycle with no result. After the closing transfer busy
// stays high through a drain phase, whose length is set by the length of the
// cell chain, while the last elements ripple down the chain of compare cells,
// then the set comes out ascending, one result per cycle on out_valid, with
// end_of_run on the greatest value. The receiver cannot stall: every result
// is on the ports for exactly one cycle. Busy drops in the cycle that carries
// the final result, so the next set can start loading while that result is on
// the ports.
module merge_sort_engine #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire msort_pkg::in_item_t in_item,
  output logic                     out_valid,
  output msort_pkg::out_item_t     out_item
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  msort_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;   // elements in the open set
  logic [CNT_W-1:0]  step_cnt_r, step_cnt_nxt;   // drain cycles / results sent
  logic              out_valid_r, out_valid_nxt;
  msort_pkg::out_item_t out_item_r, out_item_nxt;
  logic              in_xfer;
  logic              shift_en;

  // pass[i] feeds cell i from the left, hold[i] is what cell i keeps
  msort_pkg::slot_t pass [0:MAX_ITEMS];
  msort_pkg::slot_t hold [0:MAX_ITEMS];

  assign busy    = (state_r != msort_pkg::ST_LOAD);
  assign in_xfer = start && !busy;

  assign pass[0]         = '{valid: in_xfer, data: in_item.value};
  assign hold[MAX_ITEMS] = '{valid: 1'b0, data: '0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    msort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .pass_in    (pass[i]),
      .right_hold (hold[i+1]),
      .hold       (hold[i]),
      .pass_out   (pass[i+1])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    step_cnt_nxt  = step_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    shift_en      = 1'b0;
    case (state_r)
      msort_pkg::ST_LOAD: begin
        if (in_xfer) begin
          load_cnt_nxt = load_cnt_r + CNT_W'(1);
          // set closes on last_item or when the store fills
          if (in_item.last_item || (load_cnt_r == CNT_W'(MAX_ITEMS - 1))) begin
            state_nxt    = msort_pkg::ST_DRAIN;
            step_cnt_nxt = '0;
          end
        end
      end
      msort_pkg::ST_DRAIN: begin
        // wait until the deepest element has reached its cell
        step_cnt_nxt = step_cnt_r + CNT_W'(1);
        if (step_cnt_r == CNT_W'(MAX_ITEMS - 1)) begin
          state_nxt    = msort_pkg::ST_EMIT;
          step_cnt_nxt = '0;
        end
      end
      msort_pkg::ST_EMIT: begin
        // head cell holds the smallest remaining element
        shift_en                  = 1'b1;
        out_valid_nxt             = 1'b1;
        out_item_nxt.sorted_value = hold[0].data;
        out_item_nxt.end_of_run   = (step_cnt_r + CNT_W'(1) == load_cnt_r);
        step_cnt_nxt              = step_cnt_r + CNT_W'(1);
        if (step_cnt_r + CNT_W'(1) == load_cnt_r) begin
          state_nxt    = msort_pkg::ST_LOAD;
          load_cnt_nxt = '0;
        end
      end
      default: begin
        state_nxt = msort_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msort_pkg::ST_LOAD;
      load_cnt_r  <= '0;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // end_of_run only ever rides with a strobe
  assign out_valid           = out_valid_r;
  assign out_item.sorted_value = out_item_r.sorted_value;
  assign out_item.end_of_run = out_item_r.end_of_run && out_valid_r;

  // no element may fall off the end of the chain
  `MSORT_ASSERT_NEVER(a_no_overflow, clk, rst_n, pass[MAX_ITEMS].valid)
  // while emitting, the head cell must still hold an element
  `MSORT_ASSERT_IMPLIES(a_head_valid, clk, rst_n, state_r == msort_pkg::ST_EMIT, hold[0].valid)
  // a strobe follows an emit cycle
  `MSORT_ASSERT_IMPLIES(a_strobe_src, clk, rst_n, out_valid_r, $past(state_r == msort_pkg::ST_EMIT))
  // fill count never goes past the store depth
  `MSORT_ASSERT_NEVER(a_cnt_range, clk, rst_n, load_cnt_r > CNT_W'(MAX_ITEMS))
  // the chain is empty once a run has been sent out
  `MSORT_ASSERT_IMPLIES(a_empty_after, clk, rst_n, out_item.end_of_run, !hold[0].valid)

endmodule
`default_nettype wire
